// ===== hdl/kfli_pkg.sv =====
`timescale 1ns / 1ps
package kfli_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned KIDX_W  = 5;
  localparam int unsigned CH_W    = 4;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STEPS_W = 12;
  localparam int unsigned STAT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_SET_LIVE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SAVE_KEY  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE_KEY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_COUNT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PLAY      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd5;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_STOPPED = 2'd2;
  localparam logic [STAT_W-1:0] ST_ENDED   = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [KIDX_W-1:0]        key_index;
    logic [CH_W-1:0]          channel;
    logic signed [VAL_W-1:0]  value;
  } kfli_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [CH_W-1:0]          out_channel;
    logic signed [VAL_W-1:0]  pose_value;
    logic                     playing;
    logic                     last;
  } kfli_out_t;

endpackage

// ===== hdl/kfli_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: signed 33-bit dividend by
// unsigned 12-bit divisor, quotient truncated toward zero, saturated to 32 bits.
module kfli_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             go,
  input  logic signed [32:0]               dividend,
  input  logic [kfli_pkg::STEPS_W-1:0]     divisor,
  output logic                             done,
  output logic signed [kfli_pkg::VAL_W-1:0] quotient
);

  localparam int unsigned NB = 33;

  logic [NB-1:0]                   mag_r, mag_nxt;
  logic [kfli_pkg::STEPS_W:0]      rem_r, rem_nxt;
  logic [kfli_pkg::STEPS_W-1:0]    dvs_r, dvs_nxt;
  logic                            neg_r, neg_nxt;
  logic [5:0]                      cnt_r, cnt_nxt;
  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [kfli_pkg::STEPS_W:0]      trial;
  logic signed [NB:0]              sq;

  always_comb begin
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[kfli_pkg::STEPS_W-1:0], mag_r[NB-1]};
    if (go) begin
      neg_nxt  = dividend[32];
      mag_nxt  = dividend[32] ? NB'(-dividend) : NB'(dividend);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 6'(NB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        mag_nxt = {mag_r[NB-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        mag_nxt = {mag_r[NB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  // Magnitude fits 33 bits; apply sign and saturate.
  always_comb begin
    sq = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
    if (sq > 34'sd2147483647)       quotient = 32'sh7FFFFFFF;
    else if (sq < -34'sd2147483648) quotient = 32'sh80000000;
    else                            quotient = sq[31:0];
  end

  assign done = done_r;

endmodule

// ===== hdl/keyframe_linear_interpolator.sv =====
`timescale 1ns / 1ps
// Channel   | Handshake                  | Payload
// ----------+----------------------------+----------------------------------
// in_       | start & !busy accepts      | in_req  (kfli_in_t)
// out_      | out_strobe, no back-press. | out_res (kfli_out_t)
// cfg_      | cfg_valid & cfg_ready      | cfg_data (steps_per_segment)
//
// One request at a time. Plain commands emit one result per channel; save and
// in-segment ticks first walk all channels once (store or add). A segment
// change runs the shared divider per channel, and a play start adds the pose
// load before that.
// Reset is synchronous active low; the keyframe store is not cleared.
// Results cannot be stalled: one result leaves per cycle in channel order.
module keyframe_linear_interpolator #(
  parameter int unsigned MAX_KEYS     = 32,
  parameter int unsigned NUM_CHANNELS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  kfli_pkg::kfli_in_t                  in_req,
  output logic                                out_strobe,
  output kfli_pkg::kfli_out_t                 out_res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kfli_pkg::STEPS_W-1:0]        cfg_data
);

  localparam int unsigned CHW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned KW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CNTW = $clog2(MAX_KEYS + 1);
  localparam int unsigned MEMD = MAX_KEYS * NUM_CHANNELS;
  localparam int unsigned AW   = $clog2(MEMD);
  localparam int unsigned SW   = kfli_pkg::STEPS_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_LOAD_RD, S_LOAD_WR, S_SAVE,
    S_INC_RD0, S_INC_RD1, S_INC_DIV, S_INC_WAIT, S_TICK_ADD, S_EMIT
  } state_t;

  state_t                          state_r;
  kfli_pkg::kfli_in_t              req_r;
  logic [kfli_pkg::STAT_W-1:0]     status_r;
  logic [CHW-1:0]                  ch_r;
  logic [SW-1:0]                   steps_r;
  logic [CNTW-1:0]                 key_count_r;
  logic [KW-1:0]                   seg_r;
  logic [SW-1:0]                   step_cnt_r;
  logic                            play_r;
  logic signed [31:0]              pose_r [NUM_CHANNELS];
  logic signed [31:0]              inc_r  [NUM_CHANNELS];
  logic signed [31:0]              mem    [MEMD];
  logic signed [31:0]              rd_r;
  logic signed [31:0]              key_a_r;
  logic [AW-1:0]                   rd_addr;
  logic                            rd_en;
  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  logic signed [31:0]              wr_data;
  logic                            div_go;
  logic                            div_done;
  logic signed [31:0]              div_q;
  logic [SW-1:0]                   eff_steps;
  logic signed [32:0]              diff;
  logic signed [32:0]              sum;
  logic signed [31:0]              sum_sat;

  assign eff_steps = (steps_r == '0) ? SW'(1) : steps_r;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;

  function automatic logic [AW-1:0] addr_of(input logic [KW:0] k, input logic [CHW-1:0] c);
    logic [AW+KW:0] a;
    a = (AW+KW+1)'(k) * (AW+KW+1)'(NUM_CHANNELS) + (AW+KW+1)'(c);
    return a[AW-1:0];
  endfunction

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_r <= mem[rd_addr];
  end

  kfli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (diff),
    .divisor  (eff_steps),
    .done     (div_done),
    .quotient (div_q)
  );

  assign diff = 33'(rd_r) - 33'(key_a_r);
  assign sum  = 33'(pose_r[ch_r]) + 33'(inc_r[ch_r]);
  always_comb begin
    if (sum > 33'sd2147483647)       sum_sat = 32'sh7FFFFFFF;
    else if (sum < -33'sd2147483648) sum_sat = 32'sh80000000;
    else                             sum_sat = sum[31:0];
  end

  // Memory port control from state.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = pose_r[ch_r];
    div_go  = 1'b0;
    case (state_r)
      S_IDLE: begin
      end
      S_DECODE: begin
        if (req_r.cmd == kfli_pkg::CMD_WRITE_KEY &&
            {1'b0, req_r.key_index} < 6'(MAX_KEYS) &&
            {1'b0, req_r.channel} < 5'(NUM_CHANNELS)) begin
          wr_en   = 1'b1;
          wr_addr = addr_of((KW+1)'(req_r.key_index), CHW'(req_r.channel));
          wr_data = req_r.value;
        end
      end
      S_LOAD_RD: begin
        rd_en   = 1'b1;
        rd_addr = addr_of('0, ch_r);
      end
      S_SAVE: begin
        wr_en   = 1'b1;
        wr_addr = addr_of((KW+1)'(key_count_r), ch_r);
      end
      S_INC_RD0: begin
        rd_en   = 1'b1;
        rd_addr = addr_of((KW+1)'(seg_r), ch_r);
      end
      S_INC_RD1: begin
        rd_en   = 1'b1;
        rd_addr = addr_of((KW+1)'(seg_r) + (KW+1)'(1), ch_r);
      end
      S_INC_DIV: div_go = 1'b1;
      default: begin
      end
    endcase
  end

  // Sequencer: decode, walk channels over the shared divider/adder, emit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      steps_r     <= SW'(60);
      key_count_r <= '0;
      seg_r       <= '0;
      step_cnt_r  <= '0;
      play_r      <= 1'b0;
      out_strobe  <= 1'b0;
      ch_r        <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pose_r[i] <= '0;
        inc_r[i]  <= '0;
      end
    end else begin
      out_strobe <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) steps_r <= cfg_data;
          if (start) begin
            req_r    <= in_req;
            status_r <= kfli_pkg::ST_DONE;
            ch_r     <= '0;
            state_r  <= S_DECODE;
          end
        end
        S_DECODE: begin
          state_r <= S_EMIT;
          case (req_r.cmd)
            kfli_pkg::CMD_SET_LIVE: begin
              if ({1'b0, req_r.channel} < 5'(NUM_CHANNELS))
                pose_r[CHW'(req_r.channel)] <= req_r.value;
            end
            kfli_pkg::CMD_SAVE_KEY: begin
              if (32'(key_count_r) < MAX_KEYS) state_r <= S_SAVE;
              else status_r <= kfli_pkg::ST_FULL;
            end
            kfli_pkg::CMD_SET_COUNT: begin
              if (req_r.value < 0) key_count_r <= '0;
              else if (req_r.value > 32'sd0 + $signed(32'(MAX_KEYS)))
                key_count_r <= CNTW'(MAX_KEYS);
              else key_count_r <= CNTW'(req_r.value);
            end
            kfli_pkg::CMD_PLAY: begin
              if (!play_r && 32'(key_count_r) >= 2) begin
                seg_r      <= '0;
                step_cnt_r <= '0;
                play_r     <= 1'b1;
                state_r    <= S_LOAD_RD;
              end else begin
                play_r   <= 1'b0;
                status_r <= kfli_pkg::ST_STOPPED;
              end
            end
            kfli_pkg::CMD_TICK: begin
              if (play_r) begin
                if (step_cnt_r >= eff_steps) begin
                  if (32'(seg_r) + 3 > 32'(key_count_r)) begin
                    seg_r    <= '0;
                    play_r   <= 1'b0;
                    status_r <= kfli_pkg::ST_ENDED;
                  end else begin
                    seg_r      <= seg_r + KW'(1);
                    step_cnt_r <= '0;
                    state_r    <= S_INC_RD0;
                  end
                end else begin
                  step_cnt_r <= step_cnt_r + SW'(1);
                  state_r    <= S_TICK_ADD;
                end
              end
            end
            default: begin
            end
          endcase
        end
        S_SAVE: begin
          if (32'(ch_r) == NUM_CHANNELS - 1) begin
            key_count_r <= key_count_r + CNTW'(1);
            ch_r        <= '0;
            state_r     <= S_EMIT;
          end else ch_r <= ch_r + CHW'(1);
        end
        S_LOAD_RD: state_r <= S_LOAD_WR;
        S_LOAD_WR: begin
          pose_r[ch_r] <= rd_r;
          if (32'(ch_r) == NUM_CHANNELS - 1) begin
            ch_r <= '0;
            // A single-key store has no second row: keep increments.
            state_r <= (MAX_KEYS > 1) ? S_INC_RD0 : S_EMIT;
          end else begin
            ch_r    <= ch_r + CHW'(1);
            state_r <= S_LOAD_RD;
          end
        end
        S_INC_RD0: state_r <= S_INC_RD1;
        S_INC_RD1: begin
          key_a_r <= rd_r;
          state_r <= S_INC_DIV;
        end
        S_INC_DIV: state_r <= S_INC_WAIT;
        S_INC_WAIT: begin
          if (div_done) begin
            inc_r[ch_r] <= div_q;
            if (32'(ch_r) == NUM_CHANNELS - 1) begin
              ch_r    <= '0;
              state_r <= S_EMIT;
            end else begin
              ch_r    <= ch_r + CHW'(1);
              state_r <= S_INC_RD0;
            end
          end
        end
        S_TICK_ADD: begin
          pose_r[ch_r] <= sum_sat;
          if (32'(ch_r) == NUM_CHANNELS - 1) begin
            ch_r    <= '0;
            state_r <= S_EMIT;
          end else ch_r <= ch_r + CHW'(1);
        end
        S_EMIT: begin
          out_strobe          <= 1'b1;
          out_res.status      <= status_r;
          out_res.out_channel <= kfli_pkg::CH_W'(ch_r);
          out_res.pose_value  <= pose_r[ch_r];
          out_res.playing     <= play_r;
          out_res.last        <= (32'(ch_r) == NUM_CHANNELS - 1);
          if (32'(ch_r) == NUM_CHANNELS - 1) begin
            ch_r    <= '0;
            state_r <= S_IDLE;
          end else ch_r <= ch_r + CHW'(1);
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
